// ===== sv/fdm_pkg.sv =====
// ----------------------------------------------------------------------------
// fdm_pkg: shared types and constants
// Sizes, operation and result codes, chain commands and the sigmoid table.
// ----------------------------------------------------------------------------
package fdm_pkg;

    localparam int DISPLAY_ROWS = 32;
    localparam int DISPLAY_COLS = 64;
    localparam int HIDDEN_UNITS = 32;
    localparam int OUTPUT_UNITS = 1;
    localparam int WEIGHT_BITS  = 16;

    localparam int KEEP_BITS = (WEIGHT_BITS < 16) ? WEIGHT_BITS : 16;
    localparam int PIXELS    = DISPLAY_ROWS * DISPLAY_COLS;
    localparam int PIX_AW    = $clog2(PIXELS);
    localparam int W1_DEPTH  = HIDDEN_UNITS * PIXELS;
    localparam int W1_AW     = $clog2(W1_DEPTH);
    localparam int W2_DEPTH  = OUTPUT_UNITS * HIDDEN_UNITS;
    localparam int W2_AW     = $clog2(W2_DEPTH);
    localparam int HC_W      = $clog2(HIDDEN_UNITS + 1);
    localparam int OC_W      = $clog2(OUTPUT_UNITS + 1);
    localparam int SUM_W     = 32;

    typedef enum logic [1:0] {
        OP_W1    = 2'd0,
        OP_W2    = 2'd1,
        OP_PIXEL = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        KIND_DIFF   = 2'd0,
        KIND_HIDDEN = 2'd1,
        KIND_OUTPUT = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        CH_HOLD,
        CH_ADD,
        CH_SUB,
        CH_RELU,
        CH_ROT,
        CH_CLEAR
    } t_chain_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_ACC,
        ST_HID,
        ST_L2,
        ST_ABS,
        ST_RND,
        ST_TAB,
        ST_MUL,
        ST_OUT
    } t_state;

    // round(65536 * sigmoid(k/2))
    function automatic logic [16:0] sig_lut(input logic [4:0] k);
        logic [16:0] r;
        unique case (k)
            5'd0:    r = 17'd32768;
            5'd1:    r = 17'd40793;
            5'd2:    r = 17'd47911;
            5'd3:    r = 17'd53581;
            5'd4:    r = 17'd57724;
            5'd5:    r = 17'd60565;
            5'd6:    r = 17'd62428;
            5'd7:    r = 17'd63615;
            5'd8:    r = 17'd64357;
            5'd9:    r = 17'd64816;
            5'd10:   r = 17'd65097;
            5'd11:   r = 17'd65269;
            5'd12:   r = 17'd65374;
            5'd13:   r = 17'd65438;
            5'd14:   r = 17'd65476;
            5'd15:   r = 17'd65500;
            default: r = 17'd65514;
        endcase
        return r;
    endfunction

endpackage

// ===== sv/frame_difference_mlp_inference.sv =====
// ----------------------------------------------------------------------------
// frame_difference_mlp_inference: frame-difference two-layer perceptron
// Pixel differencing, hidden accumulation in a cell row, sigmoid outputs.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall) carries weight writes and display
// pixels in raster order. Output channel (o_out_valid / i_out_stall) carries
// results: one frame difference per pixel; after the last pixel of a frame,
// one ReLU hidden value per hidden unit, then one sigmoid output per output
// unit, the final one flagged with o_last.
// A pixel that changed also rotates the hidden sums once through the cell
// row, one first-layer weight read per cycle from the single-port weight
// memory; an unchanged pixel does not. The end of frame then adds the hidden
// values and each output unit in turn.
// Only one request is in work at a time; o_in_stall is high while it runs.
// Reset is synchronous and takes effect at once: the previous frame reads
// as zero until a full frame has been seen, hidden sums are cleared.
// While o_out_valid and i_out_stall are both high the result register holds and the states that emit a result wait.
// ----------------------------------------------------------------------------
module frame_difference_mlp_inference
    import fdm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_operation,
    input  logic [15:0]        i_weight_address,
    input  logic signed [15:0] i_weight_value,
    input  logic               i_pixel,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_kind,
    output logic [10:0]        o_unit_index,
    output logic signed [31:0] o_value,
    output logic               o_last
);

    t_state r_state, n_state;

    logic [KEEP_BITS-1:0] r_w1_mem [W1_DEPTH];
    logic [KEEP_BITS-1:0] r_w2_mem [W2_DEPTH];
    logic                 r_prev_mem [PIXELS];
    logic [KEEP_BITS-1:0] r_w1_q;
    logic                 r_prev_q;

    logic [PIX_AW-1:0] r_pos;
    logic              r_pix;
    logic              r_warm;
    logic              r_dneg;
    logic [HC_W-1:0]   r_h;
    logic [OC_W-1:0]   r_o;
    logic [W2_AW-1:0]  r_w2a;
    logic              r_iss_done;
    logic              r_rdv, r_rdlast;
    logic              r_v1, r_l1, r_v2, r_l2;
    logic signed [KEEP_BITS-1:0] r_w2q;
    logic signed [SUM_W-1:0]     r_hq;
    logic signed [KEEP_BITS+SUM_W-1:0] r_prod;
    logic signed [63:0] r_acc;
    logic [63:0]        r_mag;
    logic               r_neg;
    logic               r_sat;
    logic [3:0]         r_idx;
    logic [10:0]        r_frac;
    logic [16:0]        r_lo;
    logic [15:0]        r_dlt;
    logic [26:0]        r_p2;

    logic               r_out_valid;
    logic [1:0]         r_kind;
    logic [10:0]        r_unit;
    logic signed [31:0] r_value;
    logic               r_last;

    logic in_acc, out_free, prev, diff_nz;
    logic last_h, last_pix, last_o;
    logic [W1_AW-1:0] w1_raddr;
    t_chain_op        ch_op;
    logic signed [SUM_W-1:0] head;
    logic [51:0]      rnd;
    logic [16:0]      sig_r;
    logic [16:0]      sig_v;
    logic [4:0]       idx_hi;

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign prev       = r_warm & r_prev_q;
    assign diff_nz    = r_pix ^ prev;
    assign last_h     = (r_h == HC_W'(HIDDEN_UNITS - 1));
    assign last_pix   = (r_pos == PIX_AW'(PIXELS - 1));
    assign last_o     = (r_o == OC_W'(OUTPUT_UNITS - 1));
    assign w1_raddr   = W1_AW'(int'(r_h) * PIXELS + int'(r_pos));
    assign rnd        = 52'((r_mag + 64'd2048) >> 12);
    assign idx_hi     = 5'(r_idx) + 5'd1;
    assign sig_r      = r_lo + 17'((28'(r_p2) + 28'd1024) >> 11);
    assign sig_v      = r_neg ? (17'd65536 - sig_r) : sig_r;

    // hidden accumulator row
    fdm_chain u_chain (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_op     (ch_op),
        .i_weight (r_w1_q),
        .o_head   (head)
    );

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and chain command
    always_comb begin
        n_state = r_state;
        ch_op   = CH_HOLD;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && i_operation == OP_PIXEL) n_state = ST_DIFF;
            end
            ST_DIFF: begin
                if (out_free) begin
                    if (diff_nz)       n_state = ST_ACC;
                    else if (last_pix) n_state = ST_HID;
                    else               n_state = ST_IDLE;
                end
            end
            ST_ACC: begin
                if (r_rdv) begin
                    ch_op = r_dneg ? CH_SUB : CH_ADD;
                    if (r_rdlast) n_state = last_pix ? ST_HID : ST_IDLE;
                end
            end
            ST_HID: begin
                if (out_free) begin
                    ch_op = CH_RELU;
                    if (last_h) n_state = ST_L2;
                end
            end
            ST_L2: begin
                if (!r_iss_done) ch_op = CH_ROT;
                if (r_v2 && r_l2) n_state = ST_ABS;
            end
            ST_ABS: n_state = ST_RND;
            ST_RND: n_state = ST_TAB;
            ST_TAB: n_state = ST_MUL;
            ST_MUL: n_state = ST_OUT;
            ST_OUT: begin
                if (out_free) begin
                    if (last_o) begin
                        ch_op   = CH_CLEAR;
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_L2;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // weight and previous-frame memories
    always_ff @(posedge i_clk) begin
        if (in_acc && i_operation == OP_W1 && {1'b0, i_weight_address} < 17'(W1_DEPTH)) begin
            r_w1_mem[W1_AW'(i_weight_address)] <= i_weight_value[KEEP_BITS-1:0];
        end
        if (r_state == ST_ACC && !r_iss_done) begin
            r_w1_q <= r_w1_mem[w1_raddr];
        end
        if (in_acc && i_operation == OP_W2 && {1'b0, i_weight_address} < 17'(W2_DEPTH)) begin
            r_w2_mem[W2_AW'(i_weight_address)] <= i_weight_value[KEEP_BITS-1:0];
        end
        if (r_state == ST_L2 && !r_iss_done) begin
            r_w2q <= r_w2_mem[r_w2a];
        end
        if (in_acc && i_operation == OP_PIXEL) begin
            r_prev_q <= r_prev_mem[r_pos];
        end
        if (r_state == ST_DIFF && out_free) begin
            r_prev_mem[r_pos] <= r_pix;
        end
    end

    // control counters and flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_warm     <= 1'b0;
            r_h        <= '0;
            r_o        <= '0;
            r_w2a      <= '0;
            r_iss_done <= 1'b0;
            r_rdv      <= 1'b0;
            r_rdlast   <= 1'b0;
            r_v1       <= 1'b0;
            r_l1       <= 1'b0;
            r_v2       <= 1'b0;
            r_l2       <= 1'b0;
        end else begin
            r_v2 <= r_v1;
            r_l2 <= r_l1;
            unique case (r_state)
                ST_DIFF: begin
                    r_h        <= '0;
                    r_iss_done <= 1'b0;
                    r_rdv      <= 1'b0;
                    if (out_free && !diff_nz) begin
                        if (last_pix) begin
                            r_warm <= 1'b1;
                            r_o    <= '0;
                        end else begin
                            r_pos <= r_pos + 1'b1;
                        end
                    end
                end
                ST_ACC: begin
                    r_rdv <= !r_iss_done;
                    if (!r_iss_done) begin
                        r_rdlast <= last_h;
                        r_h      <= r_h + 1'b1;
                        if (last_h) r_iss_done <= 1'b1;
                    end
                    if (r_rdv && r_rdlast) begin
                        r_h <= '0;
                        if (last_pix) begin
                            r_warm <= 1'b1;
                            r_o    <= '0;
                        end else begin
                            r_pos <= r_pos + 1'b1;
                        end
                    end
                end
                ST_HID: begin
                    r_w2a      <= '0;
                    r_iss_done <= 1'b0;
                    r_v1       <= 1'b0;
                    if (out_free) r_h <= last_h ? '0 : r_h + 1'b1;
                end
                ST_L2: begin
                    r_v1 <= !r_iss_done;
                    if (!r_iss_done) begin
                        r_l1  <= last_h;
                        r_h   <= last_h ? '0 : r_h + 1'b1;
                        r_w2a <= r_w2a + 1'b1;
                        if (last_h) r_iss_done <= 1'b1;
                    end
                end
                ST_OUT: begin
                    r_iss_done <= 1'b0;
                    r_v1       <= 1'b0;
                    if (out_free) begin
                        if (last_o) r_pos <= '0;
                        else        r_o   <= r_o + 1'b1;
                    end
                end
                default: r_v1 <= 1'b0;
            endcase
        end
    end

    // datapath registers: pixel latch, second layer and sigmoid
    always_ff @(posedge i_clk) begin
        if (in_acc) r_pix <= i_pixel;
        if (r_state == ST_DIFF) r_dneg <= prev;
        if (r_state == ST_L2 && !r_iss_done) r_hq <= head;
        r_prod <= r_w2q * r_hq;
        if (r_state == ST_HID || (r_state == ST_OUT && out_free)) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + 64'(r_prod);
        end
        r_neg  <= (r_state == ST_ABS) ? r_acc[63] : r_neg;
        if (r_state == ST_ABS) r_mag <= r_acc[63] ? 64'(-r_acc) : 64'(r_acc);
        r_sat  <= |rnd[51:15];
        r_idx  <= rnd[14:11];
        r_frac <= rnd[10:0];
        r_lo   <= r_sat ? sig_lut(5'd16) : sig_lut(5'(r_idx));
        r_dlt  <= r_sat ? 16'd0 : 16'(sig_lut(idx_hi) - sig_lut(5'(r_idx)));
        r_p2   <= 27'(r_dlt) * 27'(r_frac);
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= (r_state == ST_DIFF) || (r_state == ST_HID)
                        || (r_state == ST_OUT);
        end
        if (out_free) begin
            unique case (r_state)
                ST_DIFF: begin
                    r_kind  <= KIND_DIFF;
                    r_unit  <= 11'(r_pos);
                    r_value <= diff_nz ? (prev ? -32'sd1 : 32'sd1) : 32'sd0;
                    r_last  <= 1'b0;
                end
                ST_HID: begin
                    r_kind  <= KIND_HIDDEN;
                    r_unit  <= 11'(r_h);
                    r_value <= head[SUM_W-1] ? 32'sd0 : head;
                    r_last  <= 1'b0;
                end
                ST_OUT: begin
                    r_kind  <= KIND_OUTPUT;
                    r_unit  <= 11'(r_o);
                    r_value <= 32'(sig_v);
                    r_last  <= last_o;
                end
                default: r_last <= r_last;
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_kind       = r_kind;
    assign o_unit_index = r_unit;
    assign o_value      = r_value;
    assign o_last       = r_last;

endmodule

// ===== sv/fdm_cell.sv =====
// ----------------------------------------------------------------------------
// fdm_cell: one hidden accumulator cell
// Holds one hidden sum and takes i_d on a shift (its neighbor's sum, or the updated head at the tail).
// ----------------------------------------------------------------------------
module fdm_cell
    import fdm_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_shift,
    input  logic                    i_clear,
    input  logic signed [SUM_W-1:0] i_d,
    output logic signed [SUM_W-1:0] o_q
);

    logic signed [SUM_W-1:0] r_q;

    // sum register, zero after reset and at frame end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_q <= '0;
        end else if (i_shift) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

// ===== sv/fdm_chain.sv =====
// ----------------------------------------------------------------------------
// fdm_chain: rotating row of hidden accumulator cells
// The head sum is updated (add, subtract, relu or plain) and fed to the tail, or the row holds or clears.
// ----------------------------------------------------------------------------
module fdm_chain
    import fdm_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_chain_op                   i_op,
    input  logic signed [KEEP_BITS-1:0] i_weight,
    output logic signed [SUM_W-1:0]     o_head
);

    logic signed [SUM_W-1:0] cell_q [HIDDEN_UNITS];
    logic signed [SUM_W-1:0] cell_d [HIDDEN_UNITS];
    logic signed [SUM_W:0]   wide;
    logic signed [SUM_W-1:0] feed;
    logic                    shift;
    logic                    clear;

    // head update with saturation
    always_comb begin
        wide  = '0;
        feed  = cell_q[0];
        shift = 1'b1;
        clear = 1'b0;
        unique case (i_op)
            CH_ADD:   wide = (SUM_W+1)'(cell_q[0]) + (SUM_W+1)'(i_weight);
            CH_SUB:   wide = (SUM_W+1)'(cell_q[0]) - (SUM_W+1)'(i_weight);
            CH_RELU:  feed = cell_q[0][SUM_W-1] ? '0 : cell_q[0];
            CH_ROT:   feed = cell_q[0];
            CH_CLEAR: begin
                shift = 1'b0;
                clear = 1'b1;
            end
            default:  shift = 1'b0;
        endcase
        if (i_op == CH_ADD || i_op == CH_SUB) begin
            if (wide[SUM_W] != wide[SUM_W-1]) begin
                feed = wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
            end else begin
                feed = wide[SUM_W-1:0];
            end
        end
    end

    // neighbor links
    always_comb begin
        for (int k = 0; k < HIDDEN_UNITS - 1; k++) begin
            cell_d[k] = cell_q[k+1];
        end
        cell_d[HIDDEN_UNITS-1] = feed;
    end

    for (genvar g = 0; g < HIDDEN_UNITS; g++) begin : g_cell
        fdm_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (shift),
            .i_clear (clear),
            .i_d     (cell_d[g]),
            .o_q     (cell_q[g])
        );
    end

    assign o_head = cell_q[0];

endmodule
